[src/text_window_cursor_writer_core_macros.svh]
// assertion macros for the text window cursor writer
`ifndef TEXT_WINDOW_CURSOR_WRITER_CORE_MACROS_SVH
`define TEXT_WINDOW_CURSOR_WRITER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define TWCW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TWCW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TWCW_ASSERT(lbl, clk, rst, prop, msg)
`define TWCW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[src/twcw_pkg.sv]
// types, constants and microcode rom of the text window cursor writer
`timescale 1ns / 1ps
`default_nettype none
package twcw_pkg;

   localparam int WINDOWS  = 16;
   localparam int COLUMNS  = 32;
   localparam int ROWS     = 24;
   localparam int TAB_STOP = 4;

   localparam int WINDOW_W = 4;
   localparam int CODE_W   = 8;
   localparam int KIND_W   = 2;
   localparam int COLUMN_W = 5;
   localparam int ROW_OUT_W = 5;
   localparam int TILE_W   = 16;
   localparam int LEN_W    = 6;
   localparam int COLOR_W  = 2;
   localparam int WIN_IW   = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
   localparam int CHARS_W  = $clog2(COLUMNS + 1);
   localparam int ROW_W    = $clog2(ROWS + 1);
   localparam int UPC_W    = 4;

   localparam logic [CODE_W-1:0] TAB_CODE   = 8'd9;
   localparam logic [CODE_W-1:0] NL_CODE    = 8'd10;
   localparam logic [CODE_W-1:0] SPACE_CODE = 8'd32;
   localparam logic [CODE_W-1:0] PCT_CODE   = 8'd37;
   localparam logic [CODE_W-1:0] DIGIT_LO   = 8'd47;
   localparam logic [CODE_W-1:0] DIGIT_HI   = 8'd52;
   localparam logic [CODE_W-1:0] COLOR_BASE = 8'd48;
   localparam logic [TILE_W-1:0] TILE_BASE    = 16'd32;
   localparam logic [TILE_W-1:0] COLOR_STRIDE = 16'd128;

   typedef logic [UPC_W-1:0] upc_type;

   localparam upc_type UPC_IDLE = 4'd0;
   localparam upc_type UPC_PCHK = 4'd1;
   localparam upc_type UPC_PFLU = 4'd2;
   localparam upc_type UPC_COLR = 4'd3;
   localparam upc_type UPC_DISP = 4'd4;
   localparam upc_type UPC_HOLD = 4'd5;
   localparam upc_type UPC_SELC = 4'd6;
   localparam upc_type UPC_TILE = 4'd7;
   localparam upc_type UPC_ATIL = 4'd8;
   localparam upc_type UPC_TABM = 4'd9;
   localparam upc_type UPC_SCRT = 4'd10;
   localparam upc_type UPC_SCRL = 4'd11;
   localparam upc_type UPC_CCHK = 4'd12;
   localparam upc_type UPC_CMIT = 4'd13;
   localparam upc_type UPC_LDON = 4'd14;
   localparam upc_type UPC_WBK  = 4'd15;

   typedef enum logic [KIND_W-1:0] {
      KIND_TILE   = 2'd0,
      KIND_SCROLL = 2'd1,
      KIND_COMMIT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      MODE_CHAR,
      MODE_TAB,
      MODE_FLUSH
   } mode_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLR_PCT,
      OP_SET_COLOR,
      OP_SET_PCT,
      OP_SEL_CHAR,
      OP_TILE,
      OP_ROW_LAST,
      OP_LINE_DONE,
      OP_WRITE_BACK
   } op_type;

   typedef enum logic [3:0] {
      COND_ALWAYS,
      COND_REQ,
      COND_PCT,
      COND_DIGIT,
      COND_PCT_HOLD,
      COND_NL,
      COND_FULL,
      COND_FLUSH,
      COND_TAB_MORE,
      COND_ROW_OVER,
      COND_CHARS_ZERO
   } cond_type;

   typedef struct packed {
      op_type   op;
      logic     emit;
      kind_type kind;
      cond_type cond;
      upc_type  jump_true;
      upc_type  jump_false;
   } uc_word_type;

   typedef struct packed {
      uc_word_type cw;
      logic        go;
      logic        idle;
   } ctl_type;

   typedef struct packed {
      logic req_ok;
      logic pct;
      logic digit;
      logic pct_hold;
      logic nl;
      logic full;
      logic flush;
      logic tab_more;
      logic row_over;
      logic chars_zero;
      logic out_busy;
   } flags_type;

   function automatic uc_word_type uc(op_type op, logic emit, kind_type kind,
                                      cond_type cond, upc_type jt, upc_type jf);
      uc_word_type w;
      w.op         = op;
      w.emit       = emit;
      w.kind       = kind;
      w.cond       = cond;
      w.jump_true  = jt;
      w.jump_false = jf;
      return w;
   endfunction

   function automatic uc_word_type ucode_rom(upc_type a);
      uc_word_type w;
      unique case (a)
         UPC_IDLE: w = uc(OP_LOAD,       1'b0, KIND_TILE,   COND_REQ,        UPC_PCHK, UPC_IDLE);
         UPC_PCHK: w = uc(OP_NONE,       1'b0, KIND_TILE,   COND_PCT,        UPC_PFLU, UPC_DISP);
         UPC_PFLU: w = uc(OP_CLR_PCT,    1'b0, KIND_TILE,   COND_DIGIT,      UPC_COLR, UPC_TILE);
         UPC_COLR: w = uc(OP_SET_COLOR,  1'b0, KIND_TILE,   COND_ALWAYS,     UPC_WBK,  UPC_WBK);
         UPC_DISP: w = uc(OP_NONE,       1'b0, KIND_TILE,   COND_PCT_HOLD,   UPC_HOLD, UPC_SELC);
         UPC_HOLD: w = uc(OP_SET_PCT,    1'b0, KIND_TILE,   COND_ALWAYS,     UPC_WBK,  UPC_WBK);
         UPC_SELC: w = uc(OP_SEL_CHAR,   1'b0, KIND_TILE,   COND_NL,         UPC_SCRT, UPC_TILE);
         UPC_TILE: w = uc(OP_TILE,       1'b1, KIND_TILE,   COND_FULL,       UPC_SCRT, UPC_ATIL);
         UPC_ATIL: w = uc(OP_NONE,       1'b0, KIND_TILE,   COND_FLUSH,      UPC_DISP, UPC_TABM);
         UPC_TABM: w = uc(OP_NONE,       1'b0, KIND_TILE,   COND_TAB_MORE,   UPC_TILE, UPC_WBK);
         UPC_SCRT: w = uc(OP_NONE,       1'b0, KIND_TILE,   COND_ROW_OVER,   UPC_SCRL, UPC_CCHK);
         UPC_SCRL: w = uc(OP_ROW_LAST,   1'b1, KIND_SCROLL, COND_ALWAYS,     UPC_CCHK, UPC_CCHK);
         UPC_CCHK: w = uc(OP_NONE,       1'b0, KIND_TILE,   COND_CHARS_ZERO, UPC_LDON, UPC_CMIT);
         UPC_CMIT: w = uc(OP_NONE,       1'b1, KIND_COMMIT, COND_ALWAYS,     UPC_LDON, UPC_LDON);
         UPC_LDON: w = uc(OP_LINE_DONE,  1'b0, KIND_TILE,   COND_FLUSH,      UPC_DISP, UPC_WBK);
         UPC_WBK:  w = uc(OP_WRITE_BACK, 1'b0, KIND_TILE,   COND_ALWAYS,     UPC_IDLE, UPC_IDLE);
         default:  w = uc(OP_NONE,       1'b0, KIND_TILE,   COND_ALWAYS,     UPC_IDLE, UPC_IDLE);
      endcase
      return w;
   endfunction

   // true when a column count sits on a tab stop
   function automatic logic tab_stop_hit(logic [CHARS_W-1:0] n);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i <= COLUMNS / TAB_STOP; i++) begin
         hit = hit | (n == CHARS_W'(i * TAB_STOP));
      end
      return hit;
   endfunction

endpackage
`default_nettype wire

[src/twcw_if.sv]
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface twcw_req_if;
   logic                          valid;
   logic                          ready;
   logic [twcw_pkg::WINDOW_W-1:0] window;
   logic [twcw_pkg::CODE_W-1:0]   char_code;
   logic                          text_end;

   modport source (output valid, window, char_code, text_end, input ready);
   modport sink (input valid, window, char_code, text_end, output ready);
endinterface

interface twcw_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [twcw_pkg::KIND_W-1:0]    kind;
   logic [twcw_pkg::WINDOW_W-1:0]  out_window;
   logic [twcw_pkg::COLUMN_W-1:0]  column;
   logic [twcw_pkg::ROW_OUT_W-1:0] row;
   logic [twcw_pkg::TILE_W-1:0]    tile;
   logic [twcw_pkg::LEN_W-1:0]     line_length;
   logic                           last;

   modport source (output valid, kind, out_window, column, row, tile, line_length, last,
                   input ready);
   modport sink (input valid, kind, out_window, column, row, tile, line_length, last,
                 output ready);
endinterface
`default_nettype wire

[src/text_window_cursor_writer_core.sv]
// text window cursor writer top level
//
// req_chan carries one text byte per word with its window number and an
// end-of-text flag; rsp_chan returns tile writes, scroll requests and line
// commits, with last set on the final word that an input byte causes.
// Both channels use valid/ready; a word moves when both are high.
// A microcoded sequencer walks a 16-step control rom over a datapath that
// keeps every window's color, row, column count and pending percent.
// One byte is taken at a time: req_chan.ready is high only while the
// program sits at its idle step.
// The steps depend on the byte: a color code or a held percent only updates
// state, a printable byte emits one tile, a tab repeats the tile step for
// every extra space, a newline may emit a scroll request and a line commit,
// a byte that fills the line also closes it, and a held percent is first
// written out as a tile; the program takes one step per cycle unless stalled.
// A step that emits a result waits while the output register still holds an
// untaken word, so a stalled receiver just stretches the program.
// Reset (synchronous, active high) returns the program to idle, drops any
// pending result and sets every window to color 0, row 0, empty line.
`timescale 1ns / 1ps
`default_nettype none
module text_window_cursor_writer_core (
   input  logic       clock,
   input  logic       reset,
   twcw_req_if.sink   req_chan,
   twcw_rsp_if.source rsp_chan
);

   twcw_pkg::ctl_type   ctl;
   twcw_pkg::flags_type flags;

   twcw_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   twcw_dp u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan),
      .ctl   (ctl),
      .flags (flags)
   );

endmodule
`default_nettype wire

[src/twcw_seq.sv]
// microcode sequencer: step counter, control rom and conditional jumps
`timescale 1ns / 1ps
`default_nettype none
`include "text_window_cursor_writer_core_macros.svh"
module twcw_seq (
   input  logic                clock,
   input  logic                reset,
   input  twcw_pkg::flags_type flags,
   output twcw_pkg::ctl_type   ctl
);

   twcw_pkg::upc_type     upc_ff;
   twcw_pkg::upc_type     upc_in;
   twcw_pkg::uc_word_type cw;
   logic                  cond_true;
   logic                  go;

   always_comb begin
      cw = twcw_pkg::ucode_rom(upc_ff);
      unique case (cw.cond)
         twcw_pkg::COND_ALWAYS:     cond_true = 1'b1;
         twcw_pkg::COND_REQ:        cond_true = flags.req_ok;
         twcw_pkg::COND_PCT:        cond_true = flags.pct;
         twcw_pkg::COND_DIGIT:      cond_true = flags.digit;
         twcw_pkg::COND_PCT_HOLD:   cond_true = flags.pct_hold;
         twcw_pkg::COND_NL:         cond_true = flags.nl;
         twcw_pkg::COND_FULL:       cond_true = flags.full;
         twcw_pkg::COND_FLUSH:      cond_true = flags.flush;
         twcw_pkg::COND_TAB_MORE:   cond_true = flags.tab_more;
         twcw_pkg::COND_ROW_OVER:   cond_true = flags.row_over;
         twcw_pkg::COND_CHARS_ZERO: cond_true = flags.chars_zero;
         default:                   cond_true = 1'b1;
      endcase
      // an emitting step waits for room in the output register
      go = !(cw.emit && flags.out_busy);
      if (go) begin
         upc_in = cond_true ? cw.jump_true : cw.jump_false;
      end else begin
         upc_in = upc_ff;
      end
      ctl.cw   = cw;
      ctl.go   = go;
      ctl.idle = (upc_ff == twcw_pkg::UPC_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= twcw_pkg::UPC_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   `TWCW_ASSERT_NEXT(a_stall_holds_step, clock, reset, cw.emit && !go, $stable(upc_ff), "step moved during output stall")
   `TWCW_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, ctl.idle && flags.req_ok, !ctl.idle, "accepted word did not start the program")

endmodule
`default_nettype wire

[src/twcw_dp.sv]
// datapath: per-window state, working registers and output register
`timescale 1ns / 1ps
`default_nettype none
`include "text_window_cursor_writer_core_macros.svh"
module twcw_dp (
   input  logic                clock,
   input  logic                reset,
   twcw_req_if.sink            req,
   twcw_rsp_if.source          rsp,
   input  twcw_pkg::ctl_type   ctl,
   output twcw_pkg::flags_type flags
);

   localparam int WIN_IW    = twcw_pkg::WIN_IW;
   localparam int CHARS_W   = twcw_pkg::CHARS_W;
   localparam int ROW_W     = twcw_pkg::ROW_W;
   localparam int CODE_W    = twcw_pkg::CODE_W;
   localparam int COLOR_W   = twcw_pkg::COLOR_W;
   localparam int TILE_W    = twcw_pkg::TILE_W;
   localparam int COLUMN_W  = twcw_pkg::COLUMN_W;
   localparam int ROW_OUT_W = twcw_pkg::ROW_OUT_W;
   localparam int LEN_W     = twcw_pkg::LEN_W;
   localparam int WINDOW_W  = twcw_pkg::WINDOW_W;
   localparam int WINDOWS   = twcw_pkg::WINDOWS;

   // per-window state
   logic [COLOR_W-1:0] color_mem_ff [WINDOWS];
   logic [ROW_W-1:0]   row_mem_ff   [WINDOWS];
   logic [CHARS_W-1:0] chars_mem_ff [WINDOWS];
   logic               pct_mem_ff   [WINDOWS];

   // working registers
   logic [WINDOW_W-1:0] w_ff, w_in;
   logic [CODE_W-1:0]   c_ff, c_in;
   logic                end_ff, end_in;
   logic [COLOR_W-1:0]  color_ff, color_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [CHARS_W-1:0]  chars_ff, chars_in;
   logic                pct_ff, pct_in;
   logic [CODE_W-1:0]   code_ff, code_in;
   twcw_pkg::mode_type  mode_ff, mode_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   twcw_pkg::kind_type     rsp_kind_ff, rsp_kind_in;
   logic [WINDOW_W-1:0]    rsp_window_ff, rsp_window_in;
   logic [COLUMN_W-1:0]    rsp_column_ff, rsp_column_in;
   logic [ROW_OUT_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [TILE_W-1:0]      rsp_tile_ff, rsp_tile_in;
   logic [LEN_W-1:0]       rsp_len_ff, rsp_len_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [WIN_IW-1:0]  load_idx;
   logic [WIN_IW-1:0]  wb_idx;
   logic [CHARS_W-1:0] chars_plus;
   logic [TILE_W-1:0]  tile_val;
   logic               emit_now;
   logic               wb_en;
   logic               is_tab;
   logic               last_tile;
   logic               last_scroll;
   logic               last_commit;

   assign load_idx   = WIN_IW'(req.window);
   assign wb_idx     = WIN_IW'(w_ff);
   assign chars_plus = chars_ff + CHARS_W'(1);
   assign tile_val   = TILE_W'(code_ff) - twcw_pkg::TILE_BASE
                     + TILE_W'(color_ff) * twcw_pkg::COLOR_STRIDE;
   assign emit_now   = ctl.go && ctl.cw.emit;
   assign wb_en      = ctl.go && (ctl.cw.op == twcw_pkg::OP_WRITE_BACK);
   assign is_tab     = (c_ff == twcw_pkg::TAB_CODE);

   always_comb begin
      flags.req_ok     = req.valid && (32'(req.window) < WINDOWS);
      flags.pct        = pct_ff;
      flags.digit      = (c_ff > twcw_pkg::DIGIT_LO) && (c_ff < twcw_pkg::DIGIT_HI);
      flags.pct_hold   = (c_ff == twcw_pkg::PCT_CODE) && !end_ff;
      flags.nl         = (c_ff == twcw_pkg::NL_CODE);
      flags.full       = (chars_ff == CHARS_W'(twcw_pkg::COLUMNS - 1));
      flags.flush      = (mode_ff == twcw_pkg::MODE_FLUSH);
      flags.tab_more   = (mode_ff == twcw_pkg::MODE_TAB) && !twcw_pkg::tab_stop_hit(chars_ff);
      flags.row_over   = (row_ff >= ROW_W'(twcw_pkg::ROWS));
      flags.chars_zero = (chars_ff == '0);
      flags.out_busy   = rsp_valid_ff && !rsp.ready;
   end

   // lookahead for the final word of an item
   always_comb begin
      last_tile = !flags.full &&
                  ((mode_ff == twcw_pkg::MODE_CHAR) ||
                   ((mode_ff == twcw_pkg::MODE_TAB) && twcw_pkg::tab_stop_hit(chars_plus)) ||
                   ((mode_ff == twcw_pkg::MODE_FLUSH) && flags.pct_hold));
      last_scroll = flags.chars_zero;
      last_commit = (mode_ff != twcw_pkg::MODE_FLUSH) || flags.pct_hold ||
                    (flags.nl && (row_ff < ROW_W'(twcw_pkg::ROWS - 1)));
   end

   always_comb begin
      w_in     = w_ff;
      c_in     = c_ff;
      end_in   = end_ff;
      color_in = color_ff;
      row_in   = row_ff;
      chars_in = chars_ff;
      pct_in   = pct_ff;
      code_in  = code_ff;
      mode_in  = mode_ff;
      if (ctl.go) begin
         unique case (ctl.cw.op)
            twcw_pkg::OP_LOAD: begin
               if (req.valid) begin
                  w_in     = req.window;
                  c_in     = req.char_code;
                  end_in   = req.text_end;
                  color_in = color_mem_ff[load_idx];
                  row_in   = row_mem_ff[load_idx];
                  chars_in = chars_mem_ff[load_idx];
                  pct_in   = pct_mem_ff[load_idx];
               end
            end
            twcw_pkg::OP_CLR_PCT: begin
               pct_in  = 1'b0;
               code_in = twcw_pkg::PCT_CODE;
               mode_in = twcw_pkg::MODE_FLUSH;
            end
            twcw_pkg::OP_SET_COLOR: color_in = COLOR_W'(c_ff - twcw_pkg::COLOR_BASE);
            twcw_pkg::OP_SET_PCT:   pct_in = 1'b1;
            twcw_pkg::OP_SEL_CHAR: begin
               code_in = is_tab ? twcw_pkg::SPACE_CODE : c_ff;
               mode_in = is_tab ? twcw_pkg::MODE_TAB : twcw_pkg::MODE_CHAR;
            end
            twcw_pkg::OP_TILE:     chars_in = chars_plus;
            twcw_pkg::OP_ROW_LAST: row_in = ROW_W'(twcw_pkg::ROWS - 1);
            twcw_pkg::OP_LINE_DONE: begin
               row_in   = row_ff + ROW_W'(1);
               chars_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_window_in = rsp_window_ff;
      rsp_column_in = rsp_column_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_tile_in   = rsp_tile_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit_now) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = ctl.cw.kind;
         rsp_window_in = w_ff;
         rsp_column_in = '0;
         rsp_row_in    = '0;
         rsp_tile_in   = '0;
         rsp_len_in    = '0;
         unique case (ctl.cw.kind)
            twcw_pkg::KIND_TILE: begin
               rsp_column_in = COLUMN_W'(chars_ff);
               rsp_tile_in   = tile_val;
               rsp_last_in   = last_tile;
            end
            twcw_pkg::KIND_SCROLL: rsp_last_in = last_scroll;
            twcw_pkg::KIND_COMMIT: begin
               rsp_row_in  = ROW_OUT_W'(row_ff);
               rsp_len_in  = LEN_W'(chars_ff);
               rsp_last_in = last_commit;
            end
            default: rsp_last_in = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      w_ff          <= w_in;
      c_ff          <= c_in;
      end_ff        <= end_in;
      color_ff      <= color_in;
      row_ff        <= row_in;
      chars_ff      <= chars_in;
      pct_ff        <= pct_in;
      code_ff       <= code_in;
      mode_ff       <= mode_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_window_ff <= rsp_window_in;
      rsp_column_ff <= rsp_column_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_tile_ff   <= rsp_tile_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOWS; i++) begin
            color_mem_ff[i] <= '0;
            row_mem_ff[i]   <= '0;
            chars_mem_ff[i] <= '0;
            pct_mem_ff[i]   <= 1'b0;
         end
      end else if (wb_en) begin
         color_mem_ff[wb_idx] <= color_ff;
         row_mem_ff[wb_idx]   <= row_ff;
         chars_mem_ff[wb_idx] <= chars_ff;
         pct_mem_ff[wb_idx]   <= pct_ff;
      end
   end

   assign req.ready       = ctl.idle;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.kind        = rsp_kind_ff;
   assign rsp.out_window  = rsp_window_ff;
   assign rsp.column      = rsp_column_ff;
   assign rsp.row         = rsp_row_ff;
   assign rsp.tile        = rsp_tile_ff;
   assign rsp.line_length = rsp_len_ff;
   assign rsp.last        = rsp_last_ff;

   `TWCW_ASSERT(a_no_overrun, clock, reset, !(emit_now && rsp_valid_ff && !rsp.ready), "result overwritten before taken")
   `TWCW_ASSERT(a_commit_nonempty, clock, reset, !(rsp_valid_ff && (rsp_kind_ff == twcw_pkg::KIND_COMMIT) && (rsp_len_ff == '0)), "empty line committed")
   `TWCW_ASSERT(a_row_range, clock, reset, ctl.idle || (row_ff <= ROW_W'(twcw_pkg::ROWS)), "row beyond scroll limit")

endmodule
`default_nettype wire

[tb/sv/twcw_text_check.sv]
// checker that predicts the cursor writer's words and compares them with the response channel
`timescale 1ns / 1ps
module twcw_text_check
   import twcw_pkg::*;
(
   input  logic clock,
   input  logic reset,
   twcw_req_if  req_mon,
   twcw_rsp_if  rsp_mon,
   output int   words_due,
   output int   fail_count
);

   typedef struct packed {
      kind_type                kind;
      logic [WINDOW_W-1:0]     window;
      logic [COLUMN_W-1:0]     column;
      logic [ROW_OUT_W-1:0]    row;
      logic [TILE_W-1:0]       tile;
      logic [LEN_W-1:0]        line_len;
      logic                    last;
   } cursor_word_t;

   logic [COLOR_W-1:0] win_color [WINDOWS];
   logic [ROW_W-1:0]   win_row   [WINDOWS];
   logic [CHARS_W-1:0] win_chars [WINDOWS];
   logic               win_pct   [WINDOWS];

   cursor_word_t due_q[$];
   cursor_word_t got;
   cursor_word_t want;
   int           errors = 0;

   function automatic void queue_word(kind_type k, logic [WINDOW_W-1:0] w,
                                      logic [COLUMN_W-1:0] col, logic [ROW_OUT_W-1:0] r,
                                      logic [TILE_W-1:0] t, logic [LEN_W-1:0] n);
      cursor_word_t cw;
      cw.kind     = k;
      cw.window   = w;
      cw.column   = col;
      cw.row      = r;
      cw.tile     = t;
      cw.line_len = n;
      cw.last     = 1'b0;
      due_q.push_back(cw);
   endfunction

   function automatic void close_line(logic [WINDOW_W-1:0] w);
      if (win_row[w] >= ROWS) begin
         queue_word(KIND_SCROLL, w, '0, '0, '0, '0);
         win_row[w] = ROW_W'(ROWS - 1);
      end
      if (win_chars[w] != 0) begin
         queue_word(KIND_COMMIT, w, '0, ROW_OUT_W'(win_row[w]), '0, LEN_W'(win_chars[w]));
      end
      win_row[w]   = win_row[w] + 1'b1;
      win_chars[w] = '0;
   endfunction

   function automatic void place_tile(logic [WINDOW_W-1:0] w, logic [CODE_W-1:0] code);
      logic [TILE_W-1:0] t;
      t = TILE_W'(code) - TILE_BASE + TILE_W'(win_color[w]) * COLOR_STRIDE;
      queue_word(KIND_TILE, w, COLUMN_W'(win_chars[w]), '0, t, '0);
      win_chars[w] = win_chars[w] + 1'b1;
      if (win_chars[w] >= COLUMNS) begin
         close_line(w);
      end
   endfunction

   function automatic void predict_byte(logic [WINDOW_W-1:0] w, logic [CODE_W-1:0] c,
                                        logic fin);
      int           start;
      logic         first;
      logic         color_only;
      cursor_word_t tail;
      start      = due_q.size();
      color_only = 1'b0;
      if (int'(w) < WINDOWS) begin
         // a held percent either becomes a color code or is written out
         if (win_pct[w]) begin
            win_pct[w] = 1'b0;
            if (c > DIGIT_LO && c < DIGIT_HI) begin
               win_color[w] = COLOR_W'(c - COLOR_BASE);
               color_only   = 1'b1;
            end else begin
               place_tile(w, PCT_CODE);
            end
         end
         if (!color_only) begin
            if (c == PCT_CODE && !fin) begin
               win_pct[w] = 1'b1;
            end else if (c == TAB_CODE) begin
               first = (win_chars[w] % TAB_STOP) == 0;
               while (((win_chars[w] < COLUMNS) && (win_chars[w] % TAB_STOP != 0)) || first) begin
                  first = 1'b0;
                  place_tile(w, SPACE_CODE);
                  if (win_chars[w] == 0) break;
               end
            end else if (c == NL_CODE) begin
               close_line(w);
            end else begin
               place_tile(w, c);
            end
         end
      end
      if (due_q.size() > start) begin
         tail      = due_q.pop_back();
         tail.last = 1'b1;
         due_q.push_back(tail);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOWS; i++) begin
            win_color[i] = '0;
            win_row[i]   = '0;
            win_chars[i] = '0;
            win_pct[i]   = 1'b0;
         end
         due_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            predict_byte(req_mon.window, req_mon.char_code, req_mon.text_end);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.kind     = kind_type'(rsp_mon.kind);
            got.window   = rsp_mon.out_window;
            got.column   = rsp_mon.column;
            got.row      = rsp_mon.row;
            got.tile     = rsp_mon.tile;
            got.line_len = rsp_mon.line_length;
            got.last     = rsp_mon.last;
            if (due_q.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("%0t: unexpected word kind %0d window %0d column %0d row %0d tile %h len %0d last %0b",
                           $realtime, got.kind, got.window, got.column, got.row, got.tile,
                           got.line_len, got.last);
               end
            end else begin
               want = due_q.pop_front();
               if (got.kind !== want.kind || got.window !== want.window ||
                   got.column !== want.column || got.row !== want.row ||
                   got.tile !== want.tile || got.line_len !== want.line_len ||
                   got.last !== want.last) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: word mismatch", $realtime);
                     $display("  expected kind %0d window %0d column %0d row %0d tile %h len %0d last %0b",
                              want.kind, want.window, want.column, want.row, want.tile,
                              want.line_len, want.last);
                     $display("  actual   kind %0d window %0d column %0d row %0d tile %h len %0d last %0b",
                              got.kind, got.window, got.column, got.row, got.tile,
                              got.line_len, got.last);
                  end
               end
            end
         end
      end
      words_due  <= due_q.size();
      fail_count <= errors;
   end

endmodule

[tb/sv/tb.sv]
// testbench top: clock, reset, text stimulus and verdict for the cursor writer
`timescale 1ns / 1ps
module tb;
   import twcw_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   logic clock;
   logic reset;
   int   words_due;
   int   fail_count;
   int   send_idle     = 0;
   int   recv_stall    = 0;
   int   hold_requests = 0;
   int   hold_served;
   int   hold_left;
   int   items_sent    = 0;
   int   cycle_count;

   twcw_req_if req_chan ();
   twcw_rsp_if rsp_chan ();

   text_window_cursor_writer_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   twcw_text_check text_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .words_due  (words_due),
      .fail_count (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // response side: random stalls plus one long hold-off
   initial begin
      rsp_chan.ready <= 1'b0;
      hold_served = 0;
      hold_left   = 0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   task automatic send_byte(input logic [WINDOW_W-1:0] w, input logic [CODE_W-1:0] c,
                            input logic fin);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.window    <= w;
      req_chan.char_code <= c;
      req_chan.text_end  <= fin;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (words_due != 0) @(posedge clock);
   endtask

   function automatic logic [WINDOW_W-1:0] pick_window();
      if ($urandom_range(99) < 70) return WINDOW_W'($urandom_range(1));
      return WINDOW_W'($urandom_range(WINDOWS - 1));
   endfunction

   // one well-formed text ending with text_end
   task automatic send_text(input logic [WINDOW_W-1:0] w);
      int   len;
      int   pick;
      logic fin;
      len = $urandom_range(12, 1);
      for (int i = 0; i < len; i++) begin
         fin  = (i == len - 1);
         pick = $urandom_range(99);
         if (pick < 10) begin
            send_byte(w, PCT_CODE, 1'b0);
            send_byte(w, COLOR_BASE + CODE_W'($urandom_range(3)), fin);
         end else if (pick < 15) begin
            send_byte(w, PCT_CODE, fin);
         end else if (pick < 25) begin
            send_byte(w, TAB_CODE, fin);
         end else if (pick < 37) begin
            send_byte(w, NL_CODE, fin);
         end else if (pick < 40) begin
            send_byte(w, CODE_W'($urandom_range(255)), fin);
         end else begin
            send_byte(w, CODE_W'($urandom_range(126, 32)), fin);
         end
      end
   endtask

   task automatic run_phase(input int count);
      int               stop_at;
      int               pick;
      logic [WINDOW_W-1:0] w;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         w    = pick_window();
         if (pick < 60) begin
            send_text(w);
         end else if (pick < 75) begin
            // runs of line ends push rows up to the scroll point
            repeat ($urandom_range(14, 6)) send_byte(w, NL_CODE, 1'($urandom_range(1)));
         end else begin
            send_byte(WINDOW_W'($urandom_range(WINDOWS - 1)), CODE_W'($urandom_range(255)),
                      1'($urandom_range(1)));
         end
      end
      drain();
   endtask

   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.window    <= '0;
      req_chan.char_code <= '0;
      req_chan.text_end  <= 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_byte(4'd0, 8'd65, 1'b0);
      send_byte(4'd15, 8'h00, 1'b0);
      send_byte(4'd15, 8'hFF, 1'b1);
      send_byte(4'd1, PCT_CODE, 1'b0);
      send_byte(4'd1, COLOR_BASE + 8'd3, 1'b0);
      send_byte(4'd1, 8'd66, 1'b0);
      send_byte(4'd1, PCT_CODE, 1'b0);
      send_byte(4'd1, PCT_CODE, 1'b0);
      send_byte(4'd1, 8'd120, 1'b0);
      send_byte(4'd1, PCT_CODE, 1'b1);
      send_byte(4'd2, PCT_CODE, 1'b0);
      send_byte(4'd2, COLOR_BASE + 8'd2, 1'b1);
      send_byte(4'd2, PCT_CODE, 1'b0);
      send_byte(4'd2, DIGIT_HI, 1'b0);
      send_byte(4'd2, PCT_CODE, 1'b0);
      send_byte(4'd2, DIGIT_LO, 1'b1);
      send_byte(4'd3, TAB_CODE, 1'b0);
      send_byte(4'd3, 8'd97, 1'b0);
      send_byte(4'd3, TAB_CODE, 1'b0);
      send_byte(4'd3, NL_CODE, 1'b1);
      send_byte(4'd5, PCT_CODE, 1'b0);
      send_byte(4'd5, COLOR_BASE + 8'd1, 1'b0);
      send_byte(4'd5, PCT_CODE, 1'b0);
      send_byte(4'd5, COLOR_BASE + 8'd2, 1'b0);
      send_byte(4'd5, 8'd67, 1'b1);
      drain();

      hold_requests++;
      run_phase(62);
      send_idle = 60;
      run_phase(62);
      send_idle  = 0;
      recv_stall = 60;
      run_phase(62);
      send_idle  = 26;
      recv_stall = 26;
      run_phase(62);

      repeat (40) @(posedge clock);
      if (fail_count == 0 && words_due == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
